// ----- hdl/jtp_pkg.sv -----
// Package for the JT65 free-text symbol packer.
// Holds widths, counts, status codes and the character-to-digit table.
// Used by the interfaces and the top level; depends on nothing.
package jtp_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGIT_W  = 6;
    localparam int unsigned SYM_W    = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned WORD_W   = 28;
    localparam int unsigned WORD3_W  = 17;
    localparam int unsigned FRAME_W  = 72;

    localparam logic [COUNT_W-1:0] TEXT_LEN      = 4'd13;
    localparam logic [COUNT_W-1:0] WORD_ONE_END  = 4'd5;
    localparam logic [COUNT_W-1:0] WORD_TWO_END  = 4'd10;
    localparam logic [COUNT_W-1:0] SYMBOL_COUNT  = 4'd12;
    localparam logic [DIGIT_W-1:0] ALPHA_SIZE    = 6'd42;
    localparam logic [WORD_W-1:0]  RADIX         = 28'd42;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [WORD3_W-1:0] word3_t;
    typedef logic [FRAME_W-1:0] frame_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_BAD_CHAR = 2'd2
    } status_t;

    // Alphabet index of a character, ALPHA_SIZE when it is not in the alphabet.
    function automatic digit_t char_digit(input char_t c);
        digit_t d;
        case (c) inside
            [8'h30:8'h39]: d = DIGIT_W'(c - 8'h30);
            [8'h41:8'h5A]: d = DIGIT_W'(c - 8'h37);
            [8'h61:8'h7A]: d = DIGIT_W'(c - 8'h57);
            8'h20:         d = 6'd36;
            8'h2B:         d = 6'd37;
            8'h2D:         d = 6'd38;
            8'h2E:         d = 6'd39;
            8'h2F:         d = 6'd40;
            8'h3F:         d = 6'd41;
            default:       d = ALPHA_SIZE;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/jtp_char_if.sv -----
// Character channel of the JT65 free-text symbol packer.
// Carries valid, ready and one message character per item; uses jtp_pkg.
interface jtp_char_if;
    logic                  valid;
    logic                  ready;
    logic [jtp_pkg::CHAR_W-1:0] char_code;
    logic                  end_of_message;

    modport source (output valid, output char_code, output end_of_message, input ready);
    modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

// ----- hdl/jtp_sym_if.sv -----
// Symbol channel of the JT65 free-text symbol packer.
// Carries valid, ready and one channel symbol with status per item; uses jtp_pkg.
interface jtp_sym_if;
    logic                         valid;
    logic                         ready;
    logic [jtp_pkg::SYM_W-1:0]    symbol;
    logic [jtp_pkg::STATUS_W-1:0] status;
    logic                         last_symbol;

    modport source (output valid, output symbol, output status, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input status, input last_symbol, output ready);
endinterface

// ----- hdl/jt65_free_text_symbol_packer_unit.sv -----
// JT65 free-text symbol packer, top level.
// Uses jtp_pkg, jtp_char_if and jtp_sym_if.
//
// Usage:
//   chars   : one message character per item, end_of_message marks the last.
//             Lower case is folded to upper; characters past the 13th are dropped.
//   symbols : on end of message, twelve 6-bit symbols (status 0, last one marked)
//             or a single error item (symbol 0, status 1 short / 2 bad character).
// Timing:
//   A character is taken every cycle while no end-of-message item waits in the
//   input register. It is held in the input register and folded into the base-42
//   words when it leaves it (one multiply-by-42 add). The frame register is loaded
//   when the end-of-message item leaves the input register. The result frame drains
//   one symbol per cycle while symbols.ready is high, from a 72-bit shift register.
//   Characters of the next message keep flowing meanwhile; only its end-of-message
//   item waits in the input register until the previous frame has drained.
// Reset: clears the count, the words, the error flag and all pending items.
// Stall: a low symbols.ready holds the current symbol; the input side keeps
//   accepting until an end-of-message item needs the frame register.
module jt65_free_text_symbol_packer_unit (
    input  logic       clk,
    input  logic       rst_n,
    jtp_char_if.sink   chars,
    jtp_sym_if.source  symbols
);

    logic                a_valid_reg;
    jtp_pkg::char_t      a_char_reg;
    logic                a_eom_reg;

    jtp_pkg::count_t     char_count_reg, char_count_next;
    jtp_pkg::word_t      word_one_reg, word_one_next;
    jtp_pkg::word_t      word_two_reg, word_two_next;
    jtp_pkg::word3_t     word_three_reg, word_three_next;
    logic                bad_char_reg, bad_char_next;

    jtp_pkg::frame_t     frame_reg, frame_next;
    jtp_pkg::count_t     frame_cnt_reg, frame_cnt_next;
    jtp_pkg::status_t    status_reg, status_next;

    jtp_pkg::digit_t     digit;
    jtp_pkg::digit_t     digit_val;
    logic                digit_bad;
    logic                taking;
    logic                frame_free;
    logic                a_advance;
    logic                in_fire;
    logic                out_fire;
    jtp_pkg::count_t     count_upd;
    jtp_pkg::word_t      w1_upd, w2_upd;
    jtp_pkg::word3_t     w3_upd;
    logic                bad_upd;
    jtp_pkg::word_t      w1_acc, w2_acc;
    jtp_pkg::word3_t     w3_acc;

    assign out_fire   = (frame_cnt_reg != '0) && symbols.ready;
    assign frame_free = (frame_cnt_reg == '0)
                        || ((frame_cnt_reg == jtp_pkg::count_t'(1)) && symbols.ready);
    assign a_advance  = a_valid_reg && (!a_eom_reg || frame_free);
    assign chars.ready = !a_valid_reg || a_advance;
    assign in_fire    = chars.valid && chars.ready;

    assign symbols.valid       = (frame_cnt_reg != '0);
    assign symbols.symbol      = frame_reg[jtp_pkg::FRAME_W-1 -: jtp_pkg::SYM_W];
    assign symbols.status      = status_reg;
    assign symbols.last_symbol = (frame_cnt_reg == jtp_pkg::count_t'(1));

    assign digit     = jtp_pkg::char_digit(a_char_reg);
    assign digit_bad = (digit == jtp_pkg::ALPHA_SIZE);
    assign digit_val = digit_bad ? '0 : digit;
    assign taking    = (char_count_reg < jtp_pkg::TEXT_LEN);

    assign w1_acc = jtp_pkg::WORD_W'(word_one_reg * jtp_pkg::RADIX
                                     + jtp_pkg::word_t'(digit_val));
    assign w2_acc = jtp_pkg::WORD_W'(word_two_reg * jtp_pkg::RADIX
                                     + jtp_pkg::word_t'(digit_val));
    assign w3_acc = jtp_pkg::WORD3_W'(word_three_reg * jtp_pkg::word3_t'(jtp_pkg::ALPHA_SIZE)
                                      + jtp_pkg::word3_t'(digit_val));

    always_comb
    begin
        w1_upd    = word_one_reg;
        w2_upd    = word_two_reg;
        w3_upd    = word_three_reg;
        count_upd = char_count_reg;
        bad_upd   = bad_char_reg;
        if (taking)
        begin
            count_upd = char_count_reg + jtp_pkg::count_t'(1);
            bad_upd   = bad_char_reg | digit_bad;
            if (char_count_reg < jtp_pkg::WORD_ONE_END)
                w1_upd = w1_acc;
            else if (char_count_reg < jtp_pkg::WORD_TWO_END)
                w2_upd = w2_acc;
            else
                w3_upd = w3_acc;
        end
    end

    always_comb
    begin
        char_count_next = char_count_reg;
        word_one_next   = word_one_reg;
        word_two_next   = word_two_reg;
        word_three_next = word_three_reg;
        bad_char_next   = bad_char_reg;
        frame_next      = frame_reg;
        frame_cnt_next  = frame_cnt_reg;
        status_next     = status_reg;

        if (out_fire)
        begin
            frame_next     = {frame_reg[jtp_pkg::FRAME_W-jtp_pkg::SYM_W-1:0],
                              jtp_pkg::sym_t'(0)};
            frame_cnt_next = frame_cnt_reg - jtp_pkg::count_t'(1);
        end

        if (a_advance)
        begin
            if (a_eom_reg)
            begin
                char_count_next = '0;
                word_one_next   = '0;
                word_two_next   = '0;
                word_three_next = '0;
                bad_char_next   = 1'b0;
                if (count_upd < jtp_pkg::TEXT_LEN)
                begin
                    frame_next     = '0;
                    frame_cnt_next = jtp_pkg::count_t'(1);
                    status_next    = jtp_pkg::STATUS_SHORT;
                end
                else if (bad_upd)
                begin
                    frame_next     = '0;
                    frame_cnt_next = jtp_pkg::count_t'(1);
                    status_next    = jtp_pkg::STATUS_BAD_CHAR;
                end
                else
                begin
                    frame_next     = {w1_upd[jtp_pkg::WORD_W-2:0], w3_upd[15],
                                      w2_upd[jtp_pkg::WORD_W-2:0], w3_upd[16],
                                      1'b1, w3_upd[14:0]};
                    frame_cnt_next = jtp_pkg::SYMBOL_COUNT;
                    status_next    = jtp_pkg::STATUS_OK;
                end
            end
            else
            begin
                char_count_next = count_upd;
                word_one_next   = w1_upd;
                word_two_next   = w2_upd;
                word_three_next = w3_upd;
                bad_char_next   = bad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            char_count_reg <= '0;
            word_one_reg   <= '0;
            word_two_reg   <= '0;
            word_three_reg <= '0;
            bad_char_reg   <= 1'b0;
            frame_cnt_reg  <= '0;
        end
        else
        begin
            if (in_fire)
                a_valid_reg <= 1'b1;
            else if (a_advance)
                a_valid_reg <= 1'b0;
            char_count_reg <= char_count_next;
            word_one_reg   <= word_one_next;
            word_two_reg   <= word_two_next;
            word_three_reg <= word_three_next;
            bad_char_reg   <= bad_char_next;
            frame_cnt_reg  <= frame_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_char_reg <= chars.char_code;
            a_eom_reg  <= chars.end_of_message;
        end
        frame_reg  <= frame_next;
        status_reg <= status_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_cnt_reg <= jtp_pkg::SYMBOL_COUNT)
        else $error("frame count above twelve");

    assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= jtp_pkg::TEXT_LEN)
        else $error("character count above thirteen");

    assert property (@(posedge clk) disable iff (!rst_n)
        symbols.valid && (symbols.status != jtp_pkg::STATUS_OK)
        |-> symbols.last_symbol && (symbols.symbol == '0))
        else $error("error item not single or not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        a_advance && a_eom_reg |=> (frame_cnt_reg != '0) && (char_count_reg == '0))
        else $error("end of message did not load a frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        symbols.valid && !symbols.ready && !a_advance |=> $stable(frame_reg))
        else $error("frame changed while stalled");

endmodule
